// ----- rtl/core/ava_pkg.sv -----
`default_nettype none
package ava_pkg;

	localparam int NUM_CHANNELS_DEF  = 8;
	localparam int SOUND_ID_BITS_DEF = 10;

	localparam int HANDLE_W = 32;
	localparam int FADE_W   = 16;

	// request kinds
	localparam logic [2:0] KIND_PLAY     = 3'd0;
	localparam logic [2:0] KIND_STOP     = 3'd1;
	localparam logic [2:0] KIND_PAUSE    = 3'd2;
	localparam logic [2:0] KIND_RESUME   = 3'd3;
	localparam logic [2:0] KIND_QUERY    = 3'd4;
	localparam logic [2:0] KIND_FINISHED = 3'd5;

	// mixer commands
	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_START    = 3'd1;
	localparam logic [2:0] ACT_FADE_IN  = 3'd2;
	localparam logic [2:0] ACT_HALT     = 3'd3;
	localparam logic [2:0] ACT_FADE_OUT = 3'd4;
	localparam logic [2:0] ACT_PAUSE    = 3'd5;
	localparam logic [2:0] ACT_RESUME   = 3'd6;

	// query answers
	localparam logic [1:0] QS_STOPPED = 2'd0;
	localparam logic [1:0] QS_PLAYING = 2'd1;
	localparam logic [1:0] QS_PAUSED  = 2'd2;

	// scan unit control
	typedef struct packed {
		logic clear;
		logic en;
	} scan_ctl_t;

	// scan unit results
	typedef struct packed {
		logic match;    // handle found
		logic same;     // a voice of the same sound exists
		logic nonloop;  // a non-looping voice exists
		logic any;      // any voice exists
	} scan_hit_t;

endpackage
`default_nettype wire

// ----- rtl/core/ava_table.sv -----
`default_nettype none
module ava_table #(
	parameter int NUM_CHANNELS  = ava_pkg::NUM_CHANNELS_DEF,
	parameter int SOUND_ID_BITS = ava_pkg::SOUND_ID_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [$clog2(NUM_CHANNELS)-1:0]   waddr,
	input  wire logic [ava_pkg::HANDLE_W-1:0]      whandle,
	input  wire logic [SOUND_ID_BITS-1:0]          wsound,
	input  wire logic                              wloop,
	input  wire logic [$clog2(NUM_CHANNELS)-1:0]   raddr,
	output logic      [ava_pkg::HANDLE_W-1:0]      rhandle,
	output logic      [SOUND_ID_BITS-1:0]          rsound,
	output logic                                   rloop
);
	import ava_pkg::*;

	localparam int ENT_W = HANDLE_W + SOUND_ID_BITS + 1;

	// one entry per channel: {handle, sound, looping}
	logic [ENT_W-1:0] mem [NUM_CHANNELS];
	logic [ENT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {whandle, wsound, wloop};
		end
		rdata_q <= mem[raddr];
	end

	assign rhandle = rdata_q[ENT_W-1 -: HANDLE_W];
	assign rsound  = rdata_q[SOUND_ID_BITS:1];
	assign rloop   = rdata_q[0];

endmodule
`default_nettype wire

// ----- rtl/core/ava_scan.sv -----
`default_nettype none
module ava_scan #(
	parameter int NUM_CHANNELS  = ava_pkg::NUM_CHANNELS_DEF,
	parameter int SOUND_ID_BITS = ava_pkg::SOUND_ID_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ava_pkg::scan_ctl_t                ctl,
	input  wire logic [$clog2(NUM_CHANNELS)-1:0]   idx,
	input  wire logic                              ent_valid,
	input  wire logic [ava_pkg::HANDLE_W-1:0]      ent_handle,
	input  wire logic [SOUND_ID_BITS-1:0]          ent_sound,
	input  wire logic                              ent_loop,
	input  wire logic [ava_pkg::HANDLE_W-1:0]      key_handle,
	input  wire logic [SOUND_ID_BITS-1:0]          key_sound,
	output ava_pkg::scan_hit_t                     hit,
	output logic      [$clog2(NUM_CHANNELS)-1:0]   match_idx,
	output logic      [$clog2(NUM_CHANNELS)-1:0]   same_idx,
	output logic      [$clog2(NUM_CHANNELS)-1:0]   nonloop_idx,
	output logic      [$clog2(NUM_CHANNELS)-1:0]   any_idx
);
	import ava_pkg::*;

	localparam int CW = $clog2(NUM_CHANNELS);

	scan_hit_t           hit_q;
	logic [CW-1:0]       match_idx_q, same_idx_q, nonloop_idx_q, any_idx_q;
	logic [HANDLE_W-1:0] same_h_q, nonloop_h_q, any_h_q;

	// strict less-than keeps the lowest channel on equal handles
	logic upd_match, upd_same, upd_nonloop, upd_any;

	always_comb begin
		upd_match   = ent_valid && !hit_q.match && (ent_handle == key_handle);
		upd_same    = ent_valid && (ent_sound == key_sound) &&
		              (!hit_q.same || (ent_handle < same_h_q));
		upd_nonloop = ent_valid && !ent_loop &&
		              (!hit_q.nonloop || (ent_handle < nonloop_h_q));
		upd_any     = ent_valid && (!hit_q.any || (ent_handle < any_h_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (ctl.clear) begin
			hit_q <= '0;
		end else if (ctl.en) begin
			if (upd_match) begin
				hit_q.match <= 1'b1;
			end
			if (upd_same) begin
				hit_q.same <= 1'b1;
			end
			if (upd_nonloop) begin
				hit_q.nonloop <= 1'b1;
			end
			if (upd_any) begin
				hit_q.any <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (upd_match) begin
				match_idx_q <= idx;
			end
			if (upd_same) begin
				same_idx_q <= idx;
				same_h_q   <= ent_handle;
			end
			if (upd_nonloop) begin
				nonloop_idx_q <= idx;
				nonloop_h_q   <= ent_handle;
			end
			if (upd_any) begin
				any_idx_q <= idx;
				any_h_q   <= ent_handle;
			end
		end
	end

	assign hit         = hit_q;
	assign match_idx   = match_idx_q;
	assign same_idx    = same_idx_q;
	assign nonloop_idx = nonloop_idx_q;
	assign any_idx     = any_idx_q;

endmodule
`default_nettype wire

// ----- rtl/core/audio_voice_allocator.sv -----
`default_nettype none
// Voice allocator with stealing for a mixer of NUM_CHANNELS channels. Each
// item is a request: play, stop, pause, resume, query, or a channel-finished
// event; each item yields exactly one result item carrying the mixer command.
// Play takes the lowest free channel; with all channels busy it steals the
// oldest voice of the same sound, else the oldest non-looping voice, else the
// oldest voice (oldest = smallest handle). Handles come from a 32-bit counter
// that skips zero on wrap. The handle, sound and looping fields of each
// channel live in a small table with one write port and one registered read
// port; valid and paused bits are flops. Play with a free channel, finished
// events and unknown kinds go from accept straight to the finish state; stop,
// pause, resume, query and play on a full table first read the table one
// entry a cycle through a single compare unit. The input stalls while an item
// is in work; a finished result waits in the output register, and a new item
// is taken meanwhile, but its result is only committed once that register is
// free.
module audio_voice_allocator #(
	parameter int NUM_CHANNELS  = ava_pkg::NUM_CHANNELS_DEF,
	parameter int SOUND_ID_BITS = ava_pkg::SOUND_ID_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [9:0]  sound_id,
	input  wire logic        looping,
	input  wire logic [31:0] handle,
	input  wire logic [15:0] fade_ms,
	input  wire logic [2:0]  channel,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] out_handle,
	output logic      [2:0]  out_channel,
	output logic      [2:0]  action,
	output logic      [15:0] out_fade_ms,
	output logic             stolen,
	output logic             status,
	output logic      [1:0]  sound_state
);
	import ava_pkg::*;

	localparam int CW    = $clog2(NUM_CHANNELS);
	localparam int CNT_W = CW + 1;
	localparam int SB    = SOUND_ID_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;

	// channel flags
	logic [NUM_CHANNELS-1:0] chan_valid_q;
	logic [NUM_CHANNELS-1:0] chan_paused_q;
	logic [HANDLE_W-1:0]     last_handle_q;

	// latched request
	logic [2:0]          kind_q;
	logic [SB-1:0]       snd_q;
	logic                loop_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [FADE_W-1:0]   fade_q;
	logic [2:0]          channel_q;

	// scan counter: issue reads for 0..N-1, compare in the cycle after each read
	logic [CNT_W-1:0] cnt_q;

	// result register
	logic                out_valid_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [2:0]          out_channel_q;
	logic [2:0]          action_q;
	logic [FADE_W-1:0]   out_fade_q;
	logic                stolen_q;
	logic                status_q;
	logic [1:0]          sound_state_q;

	logic in_accept;
	logic fin_go;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// sound id narrowed or widened to the stored width
	logic [SB+9:0] snd_ext;
	assign snd_ext = {{SB{1'b0}}, sound_id};

	// lowest free channel
	logic          free_hit;
	logic [CW-1:0] free_idx;

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!chan_valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = CW'(i);
			end
		end
	end

	// table and compare unit
	logic [CW-1:0]       rd_addr;
	logic [CW-1:0]       cmp_idx;
	logic [CNT_W-1:0]    cnt_prev;
	logic [HANDLE_W-1:0] rd_handle;
	logic [SB-1:0]       rd_sound;
	logic                rd_loop;
	logic                tbl_we;
	logic [CW-1:0]       tgt;
	logic [HANDLE_W-1:0] next_handle;
	scan_ctl_t           scan_ctl;
	scan_hit_t           scan_hit;
	logic [CW-1:0]       match_idx, same_idx, nonloop_idx, any_idx;

	assign rd_addr  = cnt_q[CW-1:0];
	assign cnt_prev = cnt_q - CNT_W'(1);
	assign cmp_idx  = cnt_prev[CW-1:0];

	assign scan_ctl.clear = in_accept;
	assign scan_ctl.en    = (state_q == S_SCAN) && (cnt_q != '0);

	ava_table #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.SOUND_ID_BITS (SOUND_ID_BITS)
	) u_table (
		.clk     (clk),
		.we      (tbl_we && fin_go),
		.waddr   (tgt),
		.whandle (next_handle),
		.wsound  (snd_q),
		.wloop   (loop_q),
		.raddr   (rd_addr),
		.rhandle (rd_handle),
		.rsound  (rd_sound),
		.rloop   (rd_loop)
	);

	ava_scan #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.SOUND_ID_BITS (SOUND_ID_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.idx         (cmp_idx),
		.ent_valid   (chan_valid_q[cmp_idx]),
		.ent_handle  (rd_handle),
		.ent_sound   (rd_sound),
		.ent_loop    (rd_loop),
		.key_handle  (handle_q),
		.key_sound   (snd_q),
		.hit         (scan_hit),
		.match_idx   (match_idx),
		.same_idx    (same_idx),
		.nonloop_idx (nonloop_idx),
		.any_idx     (any_idx)
	);

	// new handle skips zero on wrap
	always_comb begin
		next_handle = last_handle_q + HANDLE_W'(1);
		if (next_handle == '0) begin
			next_handle = HANDLE_W'(1);
		end
	end

	// finished-channel index, range checked against the channel count
	logic [CW+2:0] ch_ext;
	logic          ch_ok;
	logic [CW+2:0] tgt_ext;

	assign ch_ext  = {{CW{1'b0}}, channel_q};
	assign ch_ok   = (ch_ext < (CW+3)'(NUM_CHANNELS));
	assign tgt_ext = {3'b000, tgt};

	// result and state updates of the current item
	logic [2:0]        o_act;
	logic [FADE_W-1:0] o_fade;
	logic              o_stolen, o_status, o_play;
	logic [1:0]        o_state;
	logic              set_valid, clr_valid, set_paused, clr_paused;

	always_comb begin
		tgt        = '0;
		o_act      = ACT_NONE;
		o_fade     = '0;
		o_stolen   = 1'b0;
		o_status   = 1'b0;
		o_play     = 1'b0;
		o_state    = QS_STOPPED;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		set_paused = 1'b0;
		clr_paused = 1'b0;
		tbl_we     = 1'b0;
		case (kind_q)
			KIND_PLAY: begin
				// steal order: same sound, non-looping, any
				if (free_hit) begin
					tgt = free_idx;
				end else if (scan_hit.same) begin
					tgt = same_idx;
				end else if (scan_hit.nonloop) begin
					tgt = nonloop_idx;
				end else if (scan_hit.any) begin
					tgt = any_idx;
				end
				o_stolen   = !free_hit;
				o_play     = 1'b1;
				set_valid  = 1'b1;
				clr_paused = 1'b1;
				tbl_we     = 1'b1;
				if (fade_q != '0) begin
					o_act  = ACT_FADE_IN;
					o_fade = fade_q;
				end else begin
					o_act = ACT_START;
				end
			end
			KIND_STOP, KIND_PAUSE, KIND_RESUME, KIND_QUERY: begin
				if (!scan_hit.match) begin
					o_status = 1'b1;
				end else begin
					tgt = match_idx;
					case (kind_q)
						KIND_STOP: begin
							// a fade-out frees the channel on its finished event
							if (fade_q != '0) begin
								o_act  = ACT_FADE_OUT;
								o_fade = fade_q;
							end else begin
								o_act      = ACT_HALT;
								clr_valid  = 1'b1;
								clr_paused = 1'b1;
							end
						end
						KIND_PAUSE: begin
							if (!chan_paused_q[match_idx]) begin
								o_act      = ACT_PAUSE;
								set_paused = 1'b1;
							end
						end
						KIND_RESUME: begin
							if (chan_paused_q[match_idx]) begin
								o_act      = ACT_RESUME;
								clr_paused = 1'b1;
							end
						end
						default: begin
							o_state = chan_paused_q[match_idx] ? QS_PAUSED : QS_PLAYING;
						end
					endcase
				end
			end
			KIND_FINISHED: begin
				if (ch_ok) begin
					tgt = ch_ext[CW-1:0];
					if (chan_valid_q[ch_ext[CW-1:0]]) begin
						clr_valid  = 1'b1;
						clr_paused = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, channel flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			chan_valid_q  <= '0;
			chan_paused_q <= '0;
			last_handle_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// a commit refills the register even as the old item leaves
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cnt_q <= '0;
						if ((kind == KIND_PLAY && !free_hit) ||
						    (kind inside {[KIND_STOP:KIND_QUERY]})) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_CHANNELS)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (o_play) begin
							last_handle_q <= next_handle;
						end
						if (set_valid) begin
							chan_valid_q[tgt] <= 1'b1;
						end
						if (clr_valid) begin
							chan_valid_q[tgt] <= 1'b0;
						end
						if (set_paused) begin
							chan_paused_q[tgt] <= 1'b1;
						end
						if (clr_paused) begin
							chan_paused_q[tgt] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q    <= kind;
			snd_q     <= snd_ext[SB-1:0];
			loop_q    <= looping;
			handle_q  <= handle;
			fade_q    <= fade_ms;
			channel_q <= channel;
		end
		if (fin_go) begin
			out_handle_q  <= o_play ? next_handle : '0;
			out_channel_q <= tgt_ext[2:0];
			action_q      <= o_act;
			out_fade_q    <= o_fade;
			stolen_q      <= o_stolen;
			status_q      <= o_status;
			sound_state_q <= o_state;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_handle  = out_handle_q;
	assign out_channel = out_channel_q;
	assign action      = action_q;
	assign out_fade_ms = out_fade_q;
	assign stolen      = stolen_q;
	assign status      = status_q;
	assign sound_state = sound_state_q;

	// a started voice always carries a live, nonzero handle
	a_start_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (action_q == ACT_START || action_q == ACT_FADE_IN)
		|-> out_handle_q != '0)
		else $error("started voice without handle");

	// a lookup miss issues no command
	a_miss_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> action_q == ACT_NONE && out_handle_q == '0)
		else $error("command issued on handle miss");

	// stealing happens only on a full table
	a_steal_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stolen_q |-> &chan_valid_q)
		else $error("voice stolen with a free channel");

	// the input is closed from accept until the result is committed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("item accepted while busy");

endmodule
`default_nettype wire
